// ----- design/graph_hop_distance_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the graph hop distance core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_HOP_DISTANCE_CORE_MACROS_SVH
`define GRAPH_HOP_DISTANCE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ghd_pkg.sv -----
// ----------------------------------------------------------------------------
// Graph hop distance package
// Field widths, result and action codes, and the row memory control type.
// ----------------------------------------------------------------------------
package ghd_pkg;

	localparam int NODE_W          = 6;
	localparam int DIST_W          = 6;
	localparam int STATUS_W        = 2;
	localparam int COUNT_W         = 7;
	localparam int MAX_NODES_DEF   = 64;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_NODE    = 2'd2;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

// ----- design/ghd_row_mem.sv -----
// ----------------------------------------------------------------------------
// Adjacency row memory
// Single-port row store with registered read data. Per-row valid flops make
// rows that were never written read as zero after reset.
// ----------------------------------------------------------------------------
module ghd_row_mem #(
	parameter int MAX_NODES = ghd_pkg::MAX_NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ghd_pkg::mem_ctl_t            ctl,
	input  logic [$clog2(MAX_NODES)-1:0] addr,
	input  logic [MAX_NODES-1:0]         wdata,
	output logic [MAX_NODES-1:0]         row
);

	logic [MAX_NODES-1:0] mem [MAX_NODES];
	logic [MAX_NODES-1:0] rdata_q;
	logic [MAX_NODES-1:0] row_valid_q;
	logic                 rvalid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (ctl.wr) begin
				row_valid_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rvalid_q <= row_valid_q[addr];
			end
		end
	end

	assign row = rvalid_q ? rdata_q : '0;

endmodule

// ----- design/ghd_pick.sv -----
// ----------------------------------------------------------------------------
// Frontier node picker
// Finds the lowest set bit of the pending frontier and gives its index.
// ----------------------------------------------------------------------------
module ghd_pick #(
	parameter int MAX_NODES = ghd_pkg::MAX_NODES_DEF
) (
	input  logic [MAX_NODES-1:0]         pending,
	output logic                         any,
	output logic [MAX_NODES-1:0]         onehot,
	output logic [$clog2(MAX_NODES)-1:0] idx
);

	localparam int AW = $clog2(MAX_NODES);

	always_comb begin
		onehot = pending & (~pending + {{(MAX_NODES-1){1'b0}}, 1'b1});
		idx    = '0;
		for (int j = 0; j < MAX_NODES; j++) begin
			if (onehot[j]) begin
				idx = idx | AW'(j);
			end
		end
	end

	assign any = |pending;

endmodule

// ----- design/graph_hop_distance_core.sv -----
// ----------------------------------------------------------------------------
// Graph hop distance core
// Undirected graph store with breadth-first hop count queries.
// ----------------------------------------------------------------------------
// The graph lives in a single-port adjacency row memory, one row per node, and
// every edge add and every search goes through that one port, one row per
// cycle. An edge add reads, updates and writes back both rows in turn
// (ADD_RDA, ADD_WRA, ADD_RDB, ADD_WRB) before its result. A query whose start
// equals its target, or any item with a node not below the node count, goes
// straight from IDLE to DONE. Other queries search level by level: the frontier
// nodes of each level are picked lowest index first in Q_LEVEL, their rows are
// ORed into the next frontier, and Q_EVAL checks it; each node is read at most
// once per query. The block takes one item at a time, and a finished result
// waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module graph_hop_distance_core #(
	parameter int MAX_NODES = ghd_pkg::MAX_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ghd_pkg::COUNT_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [ghd_pkg::NODE_W-1:0]     first_node,
	input  logic [ghd_pkg::NODE_W-1:0]     second_node,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ghd_pkg::STATUS_W-1:0]   status,
	output logic [ghd_pkg::DIST_W-1:0]     distance
);

	localparam int AW = $clog2(MAX_NODES);

	typedef enum logic [2:0] {
		IDLE,
		ADD_RDA,
		ADD_WRA,
		ADD_RDB,
		ADD_WRB,
		Q_LEVEL,
		Q_EVAL,
		DONE
	} state_t;

	state_t                          state_q;
	logic [ghd_pkg::COUNT_W-1:0]     count_q;
	logic [AW-1:0]                   a_q;
	logic [AW-1:0]                   b_q;
	logic [MAX_NODES-1:0]            visited_q;
	logic [MAX_NODES-1:0]            pending_q;
	logic [MAX_NODES-1:0]            next_q;
	logic [ghd_pkg::DIST_W-1:0]      hops_q;
	logic                            rd_inflight_q;
	logic [ghd_pkg::STATUS_W-1:0]    res_status_q;
	logic [ghd_pkg::DIST_W-1:0]      res_dist_q;
	logic                            out_valid_q;
	logic [ghd_pkg::STATUS_W-1:0]    status_q;
	logic [ghd_pkg::DIST_W-1:0]      distance_q;

	logic [ghd_pkg::COUNT_W-1:0]     count_eff;
	logic [MAX_NODES-1:0]            live;
	logic                            bad_node;
	logic [MAX_NODES-1:0]            start_bit;
	logic [MAX_NODES-1:0]            nxt;
	logic [ghd_pkg::DIST_W-1:0]      hops_inc;

	ghd_pkg::mem_ctl_t               mem_ctl;
	logic [AW-1:0]                   mem_addr;
	logic [MAX_NODES-1:0]            mem_wdata;
	logic [MAX_NODES-1:0]            row;
	logic [AW-1:0]                   set_idx;

	logic                            pick_any;
	logic [MAX_NODES-1:0]            pick_onehot;
	logic [AW-1:0]                   pick_idx;

	ghd_row_mem #(
		.MAX_NODES(MAX_NODES)
	) u_row_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.row   (row)
	);

	ghd_pick #(
		.MAX_NODES(MAX_NODES)
	) u_pick (
		.pending(pending_q),
		.any    (pick_any),
		.onehot (pick_onehot),
		.idx    (pick_idx)
	);

	// The count in effect is clamped to 1..MAX_NODES.
	always_comb begin
		if (count_q == '0) begin
			count_eff = ghd_pkg::COUNT_W'(1);
		end else if (count_q > ghd_pkg::COUNT_W'(MAX_NODES)) begin
			count_eff = ghd_pkg::COUNT_W'(MAX_NODES);
		end else begin
			count_eff = count_q;
		end
		for (int j = 0; j < MAX_NODES; j++) begin
			live[j] = ghd_pkg::COUNT_W'(j) < count_eff;
		end
	end

	assign bad_node = ({1'b0, first_node} >= count_eff) || ({1'b0, second_node} >= count_eff);
	assign start_bit = {{(MAX_NODES-1){1'b0}}, 1'b1} << first_node[AW-1:0];
	assign nxt       = next_q & live & ~visited_q;
	assign hops_inc  = hops_q + ghd_pkg::DIST_W'(1);

	// Row memory port sharing between edge updates and the search.
	always_comb begin
		mem_ctl  = '0;
		mem_addr = a_q;
		set_idx  = b_q;
		unique case (state_q)
			ADD_RDA: begin
				mem_ctl.rd = 1'b1;
			end
			ADD_WRA: begin
				mem_ctl.wr = 1'b1;
			end
			ADD_RDB: begin
				mem_ctl.rd = 1'b1;
				mem_addr   = b_q;
			end
			ADD_WRB: begin
				mem_ctl.wr = 1'b1;
				mem_addr   = b_q;
				set_idx    = a_q;
			end
			Q_LEVEL: begin
				mem_ctl.rd = pick_any;
				mem_addr   = pick_idx;
			end
			IDLE, Q_EVAL, DONE: begin
				mem_ctl = '0;
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
		mem_wdata = row | ({{(MAX_NODES-1){1'b0}}, 1'b1} << set_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			count_q       <= ghd_pkg::COUNT_RESET;
			a_q           <= '0;
			b_q           <= '0;
			visited_q     <= '0;
			pending_q     <= '0;
			next_q        <= '0;
			hops_q        <= '0;
			rd_inflight_q <= 1'b0;
			res_status_q  <= ghd_pkg::ST_OK;
			res_dist_q    <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ghd_pkg::ST_OK;
			distance_q    <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						a_q <= first_node[AW-1:0];
						b_q <= second_node[AW-1:0];
						if (bad_node) begin
							res_status_q <= ghd_pkg::ST_BAD_NODE;
							res_dist_q   <= '0;
							state_q      <= DONE;
						end else if (action == ghd_pkg::ACT_ADD) begin
							state_q <= ADD_RDA;
						end else if (first_node == second_node) begin
							res_status_q <= ghd_pkg::ST_OK;
							res_dist_q   <= '0;
							state_q      <= DONE;
						end else begin
							visited_q <= start_bit;
							pending_q <= start_bit;
							next_q    <= '0;
							hops_q    <= '0;
							state_q   <= Q_LEVEL;
						end
					end
				end
				ADD_RDA: state_q <= ADD_WRA;
				ADD_WRA: state_q <= ADD_RDB;
				ADD_RDB: state_q <= ADD_WRB;
				ADD_WRB: begin
					res_status_q <= ghd_pkg::ST_OK;
					res_dist_q   <= '0;
					state_q      <= DONE;
				end
				Q_LEVEL: begin
					// Row data lands in the cycle after its read was issued.
					if (rd_inflight_q) begin
						next_q <= next_q | row;
					end
					rd_inflight_q <= pick_any;
					pending_q     <= pending_q & ~pick_onehot;
					if (!pick_any) begin
						state_q <= Q_EVAL;
					end
				end
				Q_EVAL: begin
					if (nxt == '0) begin
						res_status_q <= ghd_pkg::ST_UNREACHABLE;
						res_dist_q   <= '0;
						state_q      <= DONE;
					end else begin
						visited_q <= visited_q | nxt;
						hops_q    <= hops_inc;
						if (nxt[b_q]) begin
							res_status_q <= ghd_pkg::ST_OK;
							res_dist_q   <= hops_inc;
							state_q      <= DONE;
						end else begin
							pending_q <= nxt;
							next_q    <= '0;
							state_q   <= Q_LEVEL;
						end
					end
				end
				DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						distance_q  <= res_dist_q;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign distance  = distance_q;

	`include "graph_hop_distance_core_macros.svh"

	`GHD_ASSERT_NOW(a_fail_zero_dist, out_valid && (status != ghd_pkg::ST_OK), distance == '0, "failed result carries a nonzero distance")
	`GHD_ASSERT_NOW(a_read_in_level, rd_inflight_q, (state_q == Q_LEVEL) || (state_q == Q_EVAL), "row read outstanding outside a search level")
	`GHD_ASSERT_NOW(a_pending_visited, state_q == Q_LEVEL, (pending_q & ~visited_q) == '0, "pending frontier node not marked visited")
	`GHD_ASSERT_NEXT(a_eval_no_read, state_q == Q_EVAL, !rd_inflight_q, "row read issued during level evaluation")

endmodule

// ----- tb/graph_hop_distance_core_test.sv -----
// ----------------------------------------------------------------------------
// Graph hop distance core testbench
// Drives edge adds and hop distance queries through the valid/ready ports and
// rewrites the node count between phases. A breadth-first search model of the
// adjacency store predicts every result, and the results are compared in order.
// Directed tests come first, then a long path with cuts and a growing random
// graph.
// ----------------------------------------------------------------------------
module graph_hop_distance_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 250;
	localparam int MAX_WAIT      = 17;

	typedef struct packed {
		logic [ghd_pkg::STATUS_W-1:0] status;
		logic [ghd_pkg::DIST_W-1:0]   distance;
	} hop_result_t;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_we      = 1'b0;
	logic [ghd_pkg::COUNT_W-1:0]  cfg_wdata   = '0;
	logic                         in_valid    = 1'b0;
	logic                         in_ready;
	logic                         action      = ghd_pkg::ACT_ADD;
	logic [ghd_pkg::NODE_W-1:0]   first_node  = '0;
	logic [ghd_pkg::NODE_W-1:0]   second_node = '0;
	logic                         out_valid;
	logic                         out_ready   = 1'b1;
	logic [ghd_pkg::STATUS_W-1:0] status;
	logic [ghd_pkg::DIST_W-1:0]   distance;

	// Model of the graph store and the node count register.
	logic [63:0]                  link_rows [64];
	logic [ghd_pkg::COUNT_W-1:0]  node_count_cfg = ghd_pkg::COUNT_RESET;
	hop_result_t                  pending_results [$];
	hop_result_t                  oldest_result;

	int mismatches   = 0;
	int results_seen = 0;
	int adds_sent    = 0;
	int queries_sent = 0;
	int bad_items    = 0;
	int unreachables = 0;
	int count_writes = 0;
	int longest_hops = 0;
	int stall_left   = 0;
	int idle_cycles  = 0;
	bit steady       = 1'b0;

	always #6 clk = ~clk;

	graph_hop_distance_core #(
		.MAX_NODES(ghd_pkg::MAX_NODES_DEF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.first_node(first_node),
		.second_node(second_node),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.distance(distance)
	);

	function automatic int unsigned nodes_in_use();
		if (node_count_cfg < 1) return 1;
		if (node_count_cfg > ghd_pkg::MAX_NODES_DEF) return ghd_pkg::MAX_NODES_DEF;
		return node_count_cfg;
	endfunction

	// Applies one item to the store model and returns the result it must give.
	function automatic hop_result_t predict_hops(input logic act,
			input logic [ghd_pkg::NODE_W-1:0] a, input logic [ghd_pkg::NODE_W-1:0] b);
		int unsigned cnt;
		int unsigned hops;
		logic [63:0] live;
		logic [63:0] reached;
		logic [63:0] front;
		logic [63:0] next_front;
		bit          done;
		hop_result_t r;
		cnt = nodes_in_use();
		live = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 64'd1);
		r.status = ghd_pkg::ST_OK;
		r.distance = '0;
		if (a >= cnt || b >= cnt) begin
			r.status = ghd_pkg::ST_BAD_NODE;
		end else if (act == ghd_pkg::ACT_ADD) begin
			link_rows[a][b] = 1'b1;
			link_rows[b][a] = 1'b1;
		end else begin
			reached = 64'd1 << a;
			front = reached;
			hops = 0;
			done = reached[b];
			while (!done) begin
				next_front = '0;
				for (int i = 0; i < cnt; i++)
					if (front[i]) next_front |= link_rows[i];
				next_front &= live & ~reached;
				if (next_front == '0) begin
					r.status = ghd_pkg::ST_UNREACHABLE;
					done = 1'b1;
				end else begin
					reached |= next_front;
					front = next_front;
					hops++;
					done = reached[b];
				end
			end
			if (r.status == ghd_pkg::ST_OK) r.distance = hops[ghd_pkg::DIST_W-1:0];
		end
		return r;
	endfunction

	function automatic int draw_wait();
		if (steady) return 0;
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(1, MAX_WAIT);
	endfunction

	// Mostly a node in use; bad_pct percent of the time any 6-bit index.
	function automatic logic [ghd_pkg::NODE_W-1:0] pick_node(input int unsigned bad_pct);
		if ($urandom_range(0, 99) < bad_pct)
			return ghd_pkg::NODE_W'($urandom_range(0, 63));
		return ghd_pkg::NODE_W'($urandom_range(0, nodes_in_use() - 1));
	endfunction

	task automatic push_item(input logic act, input logic [ghd_pkg::NODE_W-1:0] a,
			input logic [ghd_pkg::NODE_W-1:0] b);
		int          gap;
		hop_result_t r;
		gap = draw_wait();
		// Valid is only lowered when a gap follows, so back-to-back items keep it high.
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		first_node <= a;
		second_node <= b;
		do @(posedge clk); while (!in_ready);
		r = predict_hops(act, a, b);
		pending_results = {pending_results, r};
		if (act == ghd_pkg::ACT_ADD) adds_sent++;
		else queries_sent++;
		if (r.status == ghd_pkg::ST_BAD_NODE) bad_items++;
		if (r.status == ghd_pkg::ST_UNREACHABLE) unreachables++;
		if (r.distance > longest_hops) longest_hops = r.distance;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_node_count(input logic [ghd_pkg::COUNT_W-1:0] value);
		wait_for_results();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_count_cfg = value;
		count_writes++;
	endtask

	task automatic test_empty_graph();
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd63);
		push_item(ghd_pkg::ACT_QUERY, 6'd63, 6'd63);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd0);
	endtask

	task automatic test_edge_add();
		push_item(ghd_pkg::ACT_ADD, 6'd0, 6'd63);
		push_item(ghd_pkg::ACT_QUERY, 6'd63, 6'd0);
		push_item(ghd_pkg::ACT_ADD, 6'd63, 6'd0);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd63);
		// A self loop must not make node 1 reach anything.
		push_item(ghd_pkg::ACT_ADD, 6'd1, 6'd1);
		push_item(ghd_pkg::ACT_QUERY, 6'd1, 6'd1);
		push_item(ghd_pkg::ACT_QUERY, 6'd1, 6'd0);
		push_item(ghd_pkg::ACT_ADD, 6'd1, 6'd63);
		push_item(ghd_pkg::ACT_QUERY, 6'd1, 6'd0);
	endtask

	task automatic test_count_limits();
		set_node_count(7'd0);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd0);
		push_item(ghd_pkg::ACT_ADD, 6'd0, 6'd0);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd1);
		push_item(ghd_pkg::ACT_ADD, 6'd1, 6'd0);
		set_node_count(7'd127);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd63);
		// With two nodes the only path from 0 to 1 runs through node 63.
		set_node_count(7'd2);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd1);
		push_item(ghd_pkg::ACT_QUERY, 6'd1, 6'd2);
		push_item(ghd_pkg::ACT_QUERY, 6'd5, 6'd0);
		set_node_count(7'd64);
		push_item(ghd_pkg::ACT_QUERY, 6'd0, 6'd1);
	endtask

	// Builds a path through all 64 nodes that starts 1, 63, 0 so the edges
	// already stored do not shorten it, then queries along it.
	task automatic test_long_chain();
		int order [64];
		int link_seq [$];
		int j;
		int tmp;
		int k;
		order[0] = 1;
		order[1] = 63;
		order[2] = 0;
		for (k = 3; k < 64; k++) order[k] = k - 1;
		for (k = 63; k > 3; k--) begin
			j = $urandom_range(3, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (k = 2; k < 63; k++) link_seq = {link_seq, k};
		for (k = link_seq.size() - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = link_seq[k];
			link_seq[k] = link_seq[j];
			link_seq[j] = tmp;
		end
		steady = ($urandom_range(0, 3) == 0);
		foreach (link_seq[n]) begin
			k = link_seq[n];
			if ($urandom_range(0, 1))
				push_item(ghd_pkg::ACT_ADD, ghd_pkg::NODE_W'(order[k]),
					ghd_pkg::NODE_W'(order[k + 1]));
			else
				push_item(ghd_pkg::ACT_ADD, ghd_pkg::NODE_W'(order[k + 1]),
					ghd_pkg::NODE_W'(order[k]));
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 1))
					push_item(ghd_pkg::ACT_QUERY, ghd_pkg::NODE_W'(order[0]), pick_node(0));
				else
					push_item(ghd_pkg::ACT_QUERY, pick_node(0), pick_node(0));
			end
		end
		steady = ($urandom_range(0, 3) == 0);
		repeat (30)
			push_item(ghd_pkg::ACT_QUERY, ghd_pkg::NODE_W'(order[$urandom_range(0, 5)]),
				ghd_pkg::NODE_W'(order[$urandom_range(58, 63)]));
	endtask

	// Lowered counts cut the path; the stored edges beyond the count are ignored.
	task automatic test_cut_chain();
		logic [ghd_pkg::COUNT_W-1:0] cuts [8];
		cuts[0] = 7'd0;
		cuts[1] = 7'd2;
		cuts[2] = 7'd63;
		cuts[3] = 7'd65;
		cuts[4] = 7'd127;
		for (int c = 5; c < 8; c++) cuts[c] = ghd_pkg::COUNT_W'($urandom_range(3, 62));
		foreach (cuts[c]) begin
			set_node_count(cuts[c]);
			steady = ($urandom_range(0, 3) == 0);
			repeat (20) push_item(ghd_pkg::ACT_QUERY, pick_node(10), pick_node(10));
		end
	endtask

	task automatic test_random_graph();
		logic [ghd_pkg::COUNT_W-1:0] value;
		for (int phase = 0; phase < 16; phase++) begin
			case ($urandom_range(0, 5))
				0: value = ghd_pkg::COUNT_W'($urandom_range(0, 1));
				1: value = 7'd64;
				2: value = ghd_pkg::COUNT_W'($urandom_range(65, 127));
				default: value = ghd_pkg::COUNT_W'($urandom_range(2, 63));
			endcase
			if (phase == 0) value = 7'd1;
			if (phase == 1) value = 7'd64;
			set_node_count(value);
			steady = ($urandom_range(0, 3) == 0);
			repeat (50) begin
				if ($urandom_range(0, 3) == 0)
					push_item(ghd_pkg::ACT_ADD, pick_node(10), pick_node(10));
				else
					push_item(ghd_pkg::ACT_QUERY, pick_node(10), pick_node(10));
			end
		end
	endtask

	// Result check and receiver stalls.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with nothing expected: status %0d distance %0d",
						results_seen, status, distance);
			end else begin
				oldest_result = pending_results.pop_front();
				if (status !== oldest_result.status || distance !== oldest_result.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected status %0d distance %0d, got status %0d distance %0d",
							results_seen, oldest_result.status, oldest_result.distance,
							status, distance);
				end
			end
			stall_left = draw_wait();
			if (stall_left > 0) out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0) out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cycles);
			$display("graph_hop_distance_core: mismatch");
			$finish;
		end
	end

	initial begin
		foreach (link_rows[r]) link_rows[r] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_graph();
		test_edge_add();
		test_count_limits();
		test_long_chain();
		test_cut_chain();
		test_random_graph();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d edge adds and %0d queries over %0d node count writes.",
			adds_sent, queries_sent, count_writes);
		$display("%0d items had a bad node, %0d queries were unreachable, longest hop count %0d.",
			bad_items, unreachables, longest_hops);
		if (mismatches == 0)
			$display("graph_hop_distance_core: match");
		else
			$display("graph_hop_distance_core: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/ghd_pkg.sv
design/ghd_row_mem.sv
design/ghd_pick.sv
design/graph_hop_distance_core.sv
tb/graph_hop_distance_core_test.sv
